// File: rtl/core/stream_substring_replacer_unit_defines.svh
// assertion macros for the substring replacer
`ifndef STREAM_SUBSTRING_REPLACER_UNIT_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACER_UNIT_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define SSR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssr assertion failed");

// antecedent holds, consequent holds in the cycle after
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssr assertion failed");

`endif

// File: rtl/core/ssr_pkg.sv
// shared constants and types of the substring replacer
package ssr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int JOB_BYTES       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                    : MAX_REPLACEMENT;
   localparam int LEN_W           = 4;
   localparam int HELD_DEPTH      = MAX_PATTERN - 1;
   localparam int HELD_W          = 3;
   localparam int BYTE_IDX_W      = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W     = 8;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

   typedef struct packed {
      logic [63:0]      pattern;
      logic [LEN_W-1:0] pattern_len;
      logic [63:0]      replacement;
      logic [LEN_W-1:0] replacement_len;
   } cfg_type;

   // one run of output bytes, count is never zero inside the queue
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] data;
      logic [LEN_W-1:0]          count;
   } job_type;

   typedef struct packed {
      logic [HELD_W-1:0] held_count;
   } front_status_type;

endpackage

// File: rtl/core/stream_substring_replacer_unit.sv
// top level of the streaming substring replacer
//
// Text bytes enter on req_ (tdata = byte, tlast = end of stream); every leftmost
// non-overlapping occurrence of the pattern is swapped for the replacement and
// the text leaves on rsp_, one byte per transfer, tlast on the last byte that
// an input byte caused. Matches never span a newline: a newline or tlast on
// req_ flushes the held candidate bytes.
// The csr_ channel writes index 0 pattern bytes, 1 pattern length, 2 replacement
// bytes, 3 replacement length; a pattern write drops held bytes. Write only
// while the block is idle.
// The front end takes one byte per cycle while the queue is not full and queues
// each output run (up to eight bytes) in a four-entry queue; the back end drains
// one output byte per cycle from a registered output stage while the receiver
// is ready; the sustained rate is one byte per cycle for plain text.
// The first output byte passes through the queue entry and the registered output
// stage before it is on rsp_, and it transfers once rsp_tready is high.
// Reset empties the queue and the held bytes and clears the configuration
// registers to zero (pass-through). A stalled receiver holds rsp_ steady; the
// queue absorbs up to four runs before req_tready drops.
`include "stream_substring_replacer_unit_defines.svh"

module stream_substring_replacer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] out_byte
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_data
);

   logic [63:0]                 pattern_ff;
   logic [ssr_pkg::LEN_W-1:0]   pattern_len_ff;
   logic [63:0]                 replacement_ff;
   logic [ssr_pkg::LEN_W-1:0]   replacement_len_ff;
   ssr_pkg::cfg_type            cfg;
   logic                        csr_write;
   logic                        clear_held;
   logic                        push_valid;
   ssr_pkg::job_type            push_job;
   ssr_pkg::job_type            head;
   logic                        q_empty;
   logic                        q_full;
   logic                        pop;
   ssr_pkg::front_status_type   front_status;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign clear_held = csr_write && (csr_index == ssr_pkg::REG_PATTERN_BYTES ||
                                     csr_index == ssr_pkg::REG_PATTERN_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff         <= '0;
         pattern_len_ff     <= '0;
         replacement_ff     <= '0;
         replacement_len_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ssr_pkg::REG_PATTERN_BYTES:      pattern_ff         <= csr_data;
            ssr_pkg::REG_PATTERN_LENGTH:     pattern_len_ff     <= csr_data[ssr_pkg::LEN_W-1:0];
            ssr_pkg::REG_REPLACEMENT_BYTES:  replacement_ff     <= csr_data;
            ssr_pkg::REG_REPLACEMENT_LENGTH: replacement_len_ff <= csr_data[ssr_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // oversized lengths saturate
   assign cfg.pattern     = pattern_ff;
   assign cfg.replacement = replacement_ff;
   assign cfg.pattern_len =
      (pattern_len_ff > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) ?
         ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN) : pattern_len_ff;
   assign cfg.replacement_len =
      (replacement_len_ff > ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT)) ?
         ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT) : replacement_len_ff;

   ssr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clear_held (clear_held),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .queue_full (q_full),
      .push_valid (push_valid),
      .push_job   (push_job),
      .status     (front_status)
   );

   ssr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   ssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // a newline or end mark leaves nothing held
   `SSR_ASSERT_NEXT(a_flush_empties, clock, reset,
      req_tvalid && req_tready && !clear_held &&
      (req_tlast || req_tdata == ssr_pkg::NEWLINE_BYTE),
      front_status.held_count == '0)

   // a pattern write drops the held candidate
   `SSR_ASSERT_NEXT(a_pattern_write_clears, clock, reset,
      clear_held, front_status.held_count == '0)

   // the held candidate is always shorter than the pattern
   `SSR_ASSERT_SAME(a_held_below_pattern, clock, reset,
      1'b1,
      front_status.held_count == '0 ||
      ssr_pkg::LEN_W'(front_status.held_count) < cfg.pattern_len)

endmodule

// File: rtl/core/ssr_front.sv
// front end: candidate tracking, match detection and output run building
module ssr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  ssr_pkg::cfg_type          cfg,
   input  logic                      clear_held,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                in_byte,
   input  logic                      in_end,
   input  logic                      queue_full,
   output logic                      push_valid,
   output ssr_pkg::job_type          push_job,
   output ssr_pkg::front_status_type status
);

   logic [7:0]                     held_ff [ssr_pkg::HELD_DEPTH];
   logic [7:0]                     held_in [ssr_pkg::HELD_DEPTH];
   logic [ssr_pkg::HELD_W-1:0]     held_cnt_ff;
   logic [ssr_pkg::HELD_W-1:0]     held_cnt_in;

   logic [7:0]                     cand [ssr_pkg::MAX_PATTERN];
   logic [7:0]                     pat  [ssr_pkg::MAX_PATTERN];
   logic [ssr_pkg::MAX_PATTERN:0]  prefix_ok;
   logic [ssr_pkg::MAX_PATTERN:0]  suffix_ok;
   logic [ssr_pkg::LEN_W-1:0]      n_cand;
   logic [ssr_pkg::LEN_W-1:0]      s_sel;
   logic [ssr_pkg::LEN_W-1:0]      keep_len;
   logic                           full_match;
   logic                           flush;
   logic                           accept;
   ssr_pkg::job_type               job;

   assign in_ready          = !queue_full;
   assign accept            = in_valid && in_ready;
   assign flush             = in_end || (in_byte == ssr_pkg::NEWLINE_BYTE);
   assign n_cand            = ssr_pkg::LEN_W'(held_cnt_ff) + 1'b1;
   assign status.held_count = held_cnt_ff;

   always_comb begin
      for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
         pat[i] = cfg.pattern[8*i +: 8];
         if (i < ssr_pkg::HELD_DEPTH && ssr_pkg::HELD_W'(i) < held_cnt_ff) begin
            cand[i] = held_ff[(i < ssr_pkg::HELD_DEPTH) ? i : 0];
         end else begin
            cand[i] = in_byte;
         end
      end
   end

   // prefix_ok[s]: candidate bytes from s up to n line up with the pattern head
   always_comb begin
      for (int s = 0; s <= ssr_pkg::MAX_PATTERN; s++) begin
         prefix_ok[s] = 1'b1;
         for (int j = 0; j < ssr_pkg::MAX_PATTERN; j++) begin
            if (s + j < ssr_pkg::MAX_PATTERN &&
                ssr_pkg::LEN_W'(s + j) < n_cand &&
                cand[(s + j < ssr_pkg::MAX_PATTERN) ? s + j : 0] != pat[j]) begin
               prefix_ok[s] = 1'b0;
            end
         end
         suffix_ok[s] = prefix_ok[s] && (ssr_pkg::LEN_W'(s) <= n_cand) &&
                        ((n_cand - ssr_pkg::LEN_W'(s)) < cfg.pattern_len);
      end
   end

   // first start that can still open a match, the empty tail always can
   always_comb begin
      s_sel = n_cand;
      for (int s = ssr_pkg::MAX_PATTERN; s >= 0; s--) begin
         if (suffix_ok[s]) begin
            s_sel = ssr_pkg::LEN_W'(s);
         end
      end
   end

   assign full_match = (n_cand == cfg.pattern_len) && prefix_ok[0];
   assign keep_len   = n_cand - s_sel;

   always_comb begin
      job         = '0;
      held_cnt_in = held_cnt_ff;
      for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
         held_in[i] = held_ff[i];
      end
      if (cfg.pattern_len == '0) begin
         job.data[0] = in_byte;
         job.count   = ssr_pkg::LEN_W'(1);
         held_cnt_in = '0;
      end else if (full_match) begin
         job.data    = cfg.replacement;
         job.count   = cfg.replacement_len;
         held_cnt_in = '0;
      end else begin
         for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
            job.data[i] = cand[i];
         end
         for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
            for (int k = 0; k < ssr_pkg::MAX_PATTERN; k++) begin
               if (ssr_pkg::LEN_W'(k) == ssr_pkg::LEN_W'(i) + s_sel) begin
                  held_in[i] = cand[k];
               end
            end
         end
         if (flush) begin
            job.count   = n_cand;
            held_cnt_in = '0;
         end else begin
            job.count   = s_sel;
            held_cnt_in = keep_len[ssr_pkg::HELD_W-1:0];
         end
      end
   end

   assign push_valid = accept && (job.count != '0);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= '0;
      end else if (clear_held) begin
         held_cnt_ff <= '0;
      end else if (accept) begin
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

// File: rtl/core/ssr_queue.sv
// short job queue between front and back end
module ssr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssr_pkg::job_type push_job,
   input  logic             pop,
   output ssr_pkg::job_type head,
   output logic             empty,
   output logic             full
);

   ssr_pkg::job_type            entry_ff [ssr_pkg::QUEUE_DEPTH];
   logic [ssr_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [ssr_pkg::QPTR_W-1:0]  wr_ptr_in;
   logic [ssr_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [ssr_pkg::QPTR_W-1:0]  rd_ptr_in;
   logic [ssr_pkg::QCNT_W-1:0]  count_ff;
   logic [ssr_pkg::QCNT_W-1:0]  count_in;
   logic                        do_push;
   logic                        do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ssr_pkg::QPTR_W'(ssr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ssr_pkg::QPTR_W'(ssr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/ssr_back.sv
// back end: walks each queued run and drives the registered output
module ssr_back (
   input  logic             clock,
   input  logic             reset,
   input  ssr_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic [ssr_pkg::BYTE_IDX_W-1:0] idx_ff;
   logic [ssr_pkg::BYTE_IDX_W-1:0] idx_in;
   logic                           valid_ff;
   logic                           valid_in;
   logic [7:0]                     byte_ff;
   logic                           last_ff;
   logic                           advance;
   logic                           load;
   logic                           at_last;

   assign advance = !valid_ff || out_ready;
   assign load    = advance && !empty;
   assign at_last = (ssr_pkg::LEN_W'(idx_ff) + 1'b1) == head.count;
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = !empty;
      end
      if (load) begin
         idx_in = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.data[idx_ff];
         last_ff <= at_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// File: verif/testbench.sv
// self-checking testbench for the streaming substring replacer unit
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_ITEMS    = 125;

   localparam logic [ssr_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_FIRST = 8'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } text_out_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [7:0]                      rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ssr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                     csr_data = '0;

   // predicted register contents and held candidate bytes
   logic [63:0]               pat_bytes;
   logic [ssr_pkg::LEN_W-1:0] pat_len;
   logic [63:0]               rep_bytes;
   logic [ssr_pkg::LEN_W-1:0] rep_len;
   logic [7:0]                held [ssr_pkg::HELD_DEPTH];
   int                        held_cnt;
   text_out_type              pending_out [$];

   int errors         = 0;
   int items_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   stream_substring_replacer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [63:0] text_word(input string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic bit pattern_prefix_at(input logic [71:0] cand, input int start,
                                            input int len);
      for (int i = 0; i < len; i++)
         if (cand[8*(start+i) +: 8] != pat_bytes[8*i +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // expected output run for one input byte
   function automatic void predict_replaced_text(input logic [7:0] in_byte,
                                                 input logic end_mark);
      logic [71:0]  cand;
      logic [7:0]   run [$];
      text_out_type item;
      int           plen, rlen, n, s;
      cand = '0;
      plen = (pat_len > ssr_pkg::MAX_PATTERN) ? ssr_pkg::MAX_PATTERN : int'(pat_len);
      rlen = (rep_len > ssr_pkg::MAX_REPLACEMENT) ? ssr_pkg::MAX_REPLACEMENT
                                                  : int'(rep_len);
      if (plen == 0) begin
         for (int i = 0; i < held_cnt; i++) run.push_back(held[i]);
         run.push_back(in_byte);
         held_cnt = 0;
      end else begin
         n = 0;
         for (int i = 0; i < held_cnt && i < plen - 1; i++) begin
            cand[8*n +: 8] = held[i];
            n++;
         end
         cand[8*n +: 8] = in_byte;
         n++;
         held_cnt = 0;
         if (n == plen && pattern_prefix_at(cand, 0, n)) begin
            for (int i = 0; i < rlen; i++) run.push_back(rep_bytes[8*i +: 8]);
         end else begin
            // keep the earliest suffix that can still grow into a match
            for (s = 0; s < n; s++)
               if (n - s < plen && pattern_prefix_at(cand, s, n - s)) break;
            for (int i = 0; i < s; i++) run.push_back(cand[8*i +: 8]);
            for (int i = s; i < n; i++) begin
               held[held_cnt] = cand[8*i +: 8];
               held_cnt++;
            end
         end
      end
      if (end_mark || in_byte == ssr_pkg::NEWLINE_BYTE) begin
         for (int i = 0; i < held_cnt; i++) run.push_back(held[i]);
         held_cnt = 0;
      end
      foreach (run[i]) begin
         item.out_byte = run[i];
         item.run_last = (i == run.size() - 1);
         pending_out.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pat_bytes = '0;
         pat_len   = '0;
         rep_bytes = '0;
         rep_len   = '0;
         held_cnt  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ssr_pkg::REG_PATTERN_BYTES: begin
                  pat_bytes = csr_data;
                  held_cnt  = 0;
               end
               ssr_pkg::REG_PATTERN_LENGTH: begin
                  pat_len  = csr_data[ssr_pkg::LEN_W-1:0];
                  held_cnt = 0;
               end
               ssr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = csr_data;
               ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len = csr_data[ssr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_replaced_text(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      text_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            errors++;
            $error("out_byte: expected none, actual %02h", rsp_tdata);
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               errors++;
               $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_tdata);
            end
            if (rsp_tlast !== want.run_last) begin
               errors++;
               $error("run_last: expected %0b, actual %0b", want.run_last, rsp_tlast);
            end
         end
      end
   end

   // ends the run after a long stretch with no transfer on any channel
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic end_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= end_mark;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_text(input string s, input logic end_on_final);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], end_on_final && i == s.len() - 1);
   endtask

   // holds the sender off until every expected byte is out and the block has settled
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // unmapped index first, then the four registers, valid held high throughout
   task automatic load_config(input logic [63:0] pat, input logic [ssr_pkg::LEN_W-1:0] plen,
                              input logic [63:0] rep, input logic [ssr_pkg::LEN_W-1:0] rlen);
      logic [ssr_pkg::CSR_INDEX_W-1:0] idx [5];
      logic [63:0]                     val [5];
      idx[0] = ssr_pkg::CSR_INDEX_W'($urandom_range(2**ssr_pkg::CSR_INDEX_W - 1,
                                                    REG_UNMAPPED_FIRST));
      val[0] = {$urandom, $urandom};
      idx[1] = ssr_pkg::REG_PATTERN_BYTES;
      val[1] = pat;
      idx[2] = ssr_pkg::REG_PATTERN_LENGTH;
      val[2] = {$urandom, $urandom};
      val[2][ssr_pkg::LEN_W-1:0] = plen;
      idx[3] = ssr_pkg::REG_REPLACEMENT_BYTES;
      val[3] = rep;
      idx[4] = ssr_pkg::REG_REPLACEMENT_LENGTH;
      val[4] = {$urandom, $urandom};
      val[4][ssr_pkg::LEN_W-1:0] = rlen;
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_pass_through();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("q", 1'b1);
      wait_drained();
   endtask

   // oversized replacement length gives the longest output run
   task automatic test_match_and_flush();
      load_config(text_word("ab"), 4'd2, text_word("ABCDEFGH"), 4'd15);
      send_text("aaba\n", 1'b0);
      wait_drained();
   endtask

   task automatic test_newline_ends_match();
      load_config(text_word("x\n"), 4'd2, text_word("!"), 4'd1);
      send_text("x\nx", 1'b1);
      wait_drained();
   endtask

   task automatic test_deleted_long_match();
      load_config(text_word("aaaaaaaa"), 4'd15, '0, 4'd0);
      send_text("aaaaaaaa", 1'b0);
      wait_drained();
   endtask

   // a pattern write while bytes are held drops them silently
   task automatic test_rewrite_mid_match();
      load_config(text_word("aaaaaaaa"), 4'd8, '1, 4'd8);
      send_text("aaa", 1'b0);
      wait_drained();
      load_config(text_word("aaaaaaaa"), 4'd9, text_word("R"), 4'd1);
      send_text("a", 1'b1);
      wait_drained();
   endtask

   task automatic test_random_text(input int idle_pct, input int stall_pct, input int count);
      logic [63:0]               pat, rep;
      logic [ssr_pkg::LEN_W-1:0] plen, rlen;
      logic [7:0]                text [$];
      int                        stop, pick, eff_len, round_len, pos;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(9);
         if (pick == 0)      plen = 4'd0;
         else if (pick == 1) plen = ssr_pkg::LEN_W'($urandom_range(15, 9));
         else if (pick == 2) plen = 4'd8;
         else                plen = ssr_pkg::LEN_W'($urandom_range(4, 1));
         pick = $urandom_range(9);
         if (pick == 0)      pat = '1;
         else if (pick == 1) pat = '0;
         else begin
            for (int i = 0; i < 8; i++) begin
               pos = $urandom_range(19);
               if (pos < 8)       pat[8*i +: 8] = "a";
               else if (pos < 15) pat[8*i +: 8] = "b";
               else if (pos < 16) pat[8*i +: 8] = ssr_pkg::NEWLINE_BYTE;
               else               pat[8*i +: 8] = 8'($urandom_range(255));
            end
         end
         pick = $urandom_range(9);
         rep  = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
         rlen = ssr_pkg::LEN_W'($urandom_range(15));
         load_config(pat, plen, rep, rlen);

         // mostly pattern pieces with random content around them
         eff_len = (plen > ssr_pkg::MAX_PATTERN) ? ssr_pkg::MAX_PATTERN : int'(plen);
         round_len = $urandom_range(40, 10);
         if (round_len > stop - items_sent) round_len = stop - items_sent;
         text.delete();
         while (text.size() < round_len) begin
            pick = $urandom_range(99);
            if (pick < 35 && eff_len > 0) begin
               for (int i = 0; i < eff_len; i++) text.push_back(pat[8*i +: 8]);
            end else if (pick < 55 && eff_len > 1) begin
               pos = $urandom_range(eff_len - 1, 1);
               for (int i = 0; i < pos; i++) text.push_back(pat[8*i +: 8]);
            end else if (pick < 70) begin
               text.push_back(pat[8*$urandom_range(7) +: 8]);
            end else if (pick < 77) begin
               text.push_back(ssr_pkg::NEWLINE_BYTE);
            end else begin
               text.push_back(8'($urandom_range(255)));
            end
         end
         foreach (text[i])
            send_byte(text[i], (i == text.size() - 1) ? ($urandom_range(1) == 1)
                                                      : ($urandom_range(99) < 3));
         wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_match_and_flush();
      test_newline_ends_match();
      test_deleted_long_match();
      test_rewrite_mid_match();
      test_random_text(0, 0, PHASE_ITEMS);
      test_random_text(67, 0, PHASE_ITEMS);
      test_random_text(0, 67, PHASE_ITEMS);
      test_random_text(25, 25, PHASE_ITEMS);
      wait_drained();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
